@@ design/rgbhsv_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared types and constants of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int CH_W  = 8;
	localparam int HUE_W = 16;
	localparam int SAT_W = 16;
	// Divider lanes: hue divisor is 6*delta <= 1530, so 11 bits cover it
	localparam int DIV_W = 11;

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [SAT_W-1:0] saturation;
		chan_t            value;
	} hsv_t;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// One divider lane: partial remainder and divisor
	typedef struct packed {
		logic [DIV_W-1:0] rem;
		logic [DIV_W-1:0] dvs;
	} lane_t;

	// Data that rides alongside the divider
	typedef struct packed {
		chan_t value;
		logic  hue_zero;
		logic  sat_zero;
		logic  sat_full;
	} side_t;

	typedef struct packed {
		lane_t hue;
		lane_t sat;
		side_t side;
	} div_in_t;

endpackage

@@ design/rgbhsv_stream_if.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_stream_if
// Valid/ready stream channel carrying one payload of type T.
// ----------------------------------------------------------------------------
interface rgbhsv_stream_if #(
	parameter type T = logic
) ();

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface

@@ design/rgb_to_hsv_converter.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streaming RGB to HSV conversion, one pixel per clock while the output is
// taken; hue and saturation: Q0.FRAC_BITS, truncated or widened to 16 bits.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Payload                         Transfer
//  pix_in    in    red, green, blue (8 b each)     valid && ready
//  hsv_out   out   hue (16), saturation (16),      valid && ready
//                  value (8)
//
//  Throughput: one pixel per clock while the output is taken.
//  The divider, two quotient bits per stage, sets the depth of the pipe.
//  Reset clears every valid bit; payload registers are not reset.
//  A stall fills bubbles first, then back-pressures stage by stage;
//  each stage holds its item until the next one has room.
//
module rgb_to_hsv_converter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	rgbhsv_stream_if.sink          pix_in,
	rgbhsv_stream_if.source        hsv_out
);

	// Front end to divider
	logic                       fr_valid, fr_ready;
	rgbhsv_pkg::div_in_t        fr_data;

	// Divider to output stage
	logic                       dv_valid, dv_ready;
	logic [FRAC_BITS-1:0]       dv_hue, dv_sat;
	rgbhsv_pkg::side_t          dv_side;

	// Output stage
	logic                       out_valid_q;
	rgbhsv_pkg::hsv_t           out_q;
	logic [FRAC_BITS-1:0]       hue_c, sat_c;

	rgbhsv_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.in_data   (pix_in.data),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_data  (fr_data)
	);

	rgbhsv_div_pipe #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.hue_quot  (dv_hue),
		.sat_quot  (dv_sat),
		.out_side  (dv_side)
	);

	// Apply the special cases the divider cannot see: grey pixels give
	// hue zero, black gives saturation zero, and full saturation (an exact
	// 1.0) clamps to all ones.
	always_comb begin
		hue_c = dv_side.hue_zero ? '0 : dv_hue;
		if (dv_side.sat_zero) begin
			sat_c = '0;
		end else if (dv_side.sat_full) begin
			sat_c = '1;
		end else begin
			sat_c = dv_sat;
		end
	end

	// Output register: take a new result whenever the slot is empty or
	// its current result is transferred in this cycle.
	assign dv_ready = !out_valid_q || hsv_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dv_ready) begin
			out_valid_q <= dv_valid;
		end
	end

	// Truncate or widen the fraction to the 16-bit fields
	always_ff @(posedge clk) begin
		if (dv_ready && dv_valid) begin
			out_q.hue        <= rgbhsv_pkg::HUE_W'(hue_c);
			out_q.saturation <= rgbhsv_pkg::SAT_W'(sat_c);
			out_q.value      <= dv_side.value;
		end
	end

	assign hsv_out.valid = out_valid_q;
	assign hsv_out.data  = out_q;

endmodule

@@ design/rgbhsv_front.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_front
// Two pipeline stages: extremes and sector, then delta, numerator and divisors.
// ----------------------------------------------------------------------------
module rgbhsv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rgbhsv_pkg::pixel_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rgbhsv_pkg::div_in_t out_data
);

	logic                valid_s1, valid_s2;
	logic                rdy_s1, rdy_s2;
	rgbhsv_pkg::pixel_t  pix_s1;
	rgbhsv_pkg::chan_t   max_s1, min_s1;
	rgbhsv_pkg::sector_t sect_s1;
	rgbhsv_pkg::div_in_t prep_s2;

	rgbhsv_pkg::chan_t   mx_c, mn_c;
	rgbhsv_pkg::sector_t sect_c;

	logic [rgbhsv_pkg::CH_W-1:0]  delta_c;
	logic [rgbhsv_pkg::DIV_W-1:0] d_w, six_d, num_c;
	logic [rgbhsv_pkg::DIV_W-1:0] r_w, g_w, b_w;

	assign rdy_s2   = !valid_s2 || out_ready;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Max and min; the maximum sector is picked red, then green, then blue
	always_comb begin
		mx_c   = (in_data.red >= in_data.green) ? in_data.red : in_data.green;
		mn_c   = (in_data.red <= in_data.green) ? in_data.red : in_data.green;
		if (in_data.blue > mx_c) begin
			mx_c = in_data.blue;
		end
		if (in_data.blue < mn_c) begin
			mn_c = in_data.blue;
		end
		if (mx_c == in_data.red) begin
			sect_c = rgbhsv_pkg::SECT_RED;
		end else if (mx_c == in_data.green) begin
			sect_c = rgbhsv_pkg::SECT_GREEN;
		end else begin
			sect_c = rgbhsv_pkg::SECT_BLUE;
		end
	end

	// Numerator stays in [0, 6d), so modular 11-bit arithmetic is exact
	always_comb begin
		delta_c = max_s1 - min_s1;
		d_w     = rgbhsv_pkg::DIV_W'(delta_c);
		six_d   = (d_w << 2) + (d_w << 1);
		r_w     = rgbhsv_pkg::DIV_W'(pix_s1.red);
		g_w     = rgbhsv_pkg::DIV_W'(pix_s1.green);
		b_w     = rgbhsv_pkg::DIV_W'(pix_s1.blue);
		case (sect_s1)
			rgbhsv_pkg::SECT_RED: begin
				if (g_w >= b_w) begin
					num_c = g_w - b_w;
				end else begin
					num_c = six_d - (b_w - g_w);
				end
			end
			rgbhsv_pkg::SECT_GREEN: num_c = (d_w << 1) + b_w - r_w;
			rgbhsv_pkg::SECT_BLUE:  num_c = (d_w << 2) + r_w - g_w;
			default:                num_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			pix_s1  <= in_data;
			max_s1  <= mx_c;
			min_s1  <= mn_c;
			sect_s1 <= sect_c;
		end
		if (rdy_s2 && valid_s1) begin
			prep_s2.hue.rem       <= num_c;
			prep_s2.hue.dvs       <= six_d;
			prep_s2.sat.rem       <= d_w;
			prep_s2.sat.dvs       <= rgbhsv_pkg::DIV_W'(max_s1);
			prep_s2.side.value    <= max_s1;
			prep_s2.side.hue_zero <= (delta_c == '0);
			prep_s2.side.sat_zero <= (max_s1 == '0);
			prep_s2.side.sat_full <= (min_s1 == '0) && (max_s1 != '0);
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = prep_s2;

endmodule

@@ design/rgbhsv_div_pipe.sv @@
// ----------------------------------------------------------------------------
// rgbhsv_div_pipe
// Pipelined restoring divider, two lanes, two quotient bits per stage.
// ----------------------------------------------------------------------------
module rgbhsv_div_pipe #(
	parameter int FRAC_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  rgbhsv_pkg::div_in_t    in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [FRAC_BITS-1:0]   hue_quot,
	output logic [FRAC_BITS-1:0]   sat_quot,
	output rgbhsv_pkg::side_t      out_side
);

	localparam int STEPS = 2;
	localparam int NSTG  = (FRAC_BITS + STEPS - 1) / STEPS;

	logic                   valid_q [NSTG];
	logic                   rdy     [NSTG];
	rgbhsv_pkg::lane_t      hue_q   [NSTG];
	rgbhsv_pkg::lane_t      sat_q   [NSTG];
	logic [FRAC_BITS-1:0]   hq_q    [NSTG];
	logic [FRAC_BITS-1:0]   sq_q    [NSTG];
	rgbhsv_pkg::side_t      side_q  [NSTG];

	// One restoring step: returns {quotient bit, new remainder}
	function automatic logic [rgbhsv_pkg::DIV_W:0] div_step(
		input rgbhsv_pkg::lane_t ln
	);
		logic [rgbhsv_pkg::DIV_W:0] t;
		logic [rgbhsv_pkg::DIV_W:0] d;
		logic                       ge;
		t  = {ln.rem, 1'b0};
		d  = {1'b0, ln.dvs};
		ge = (t >= d);
		if (ge) begin
			t = t - d;
		end
		return {ge, t[rgbhsv_pkg::DIV_W-1:0]};
	endfunction

	genvar k;
	generate
		for (k = 0; k < NSTG; k++) begin : g_stg
			logic                   vin;
			rgbhsv_pkg::lane_t      hin, sin, hnx, snx;
			logic [FRAC_BITS-1:0]   hqin, sqin, hqnx, sqnx;
			rgbhsv_pkg::side_t      sdin;
			logic [rgbhsv_pkg::DIV_W:0] hr, sr;

			if (k == 0) begin : g_first
				assign vin  = in_valid;
				assign hin  = in_data.hue;
				assign sin  = in_data.sat;
				assign hqin = '0;
				assign sqin = '0;
				assign sdin = in_data.side;
			end else begin : g_next
				assign vin  = valid_q[k-1];
				assign hin  = hue_q[k-1];
				assign sin  = sat_q[k-1];
				assign hqin = hq_q[k-1];
				assign sqin = sq_q[k-1];
				assign sdin = side_q[k-1];
			end

			if (k == NSTG - 1) begin : g_last_rdy
				assign rdy[k] = !valid_q[k] || out_ready;
			end else begin : g_mid_rdy
				assign rdy[k] = !valid_q[k] || rdy[k+1];
			end

			// Skip the spare step when FRAC_BITS is odd
			always_comb begin
				hnx  = hin;
				snx  = sin;
				hqnx = hqin;
				sqnx = sqin;
				hr   = '0;
				sr   = '0;
				for (int j = 0; j < STEPS; j++) begin
					if (k * STEPS + j < FRAC_BITS) begin
						hr      = div_step(hnx);
						sr      = div_step(snx);
						hnx.rem = hr[rgbhsv_pkg::DIV_W-1:0];
						snx.rem = sr[rgbhsv_pkg::DIV_W-1:0];
						hqnx    = {hqnx[FRAC_BITS-2:0], hr[rgbhsv_pkg::DIV_W]};
						sqnx    = {sqnx[FRAC_BITS-2:0], sr[rgbhsv_pkg::DIV_W]};
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_q[k] <= 1'b0;
				end else if (rdy[k]) begin
					valid_q[k] <= vin;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && vin) begin
					hue_q[k]  <= hnx;
					sat_q[k]  <= snx;
					hq_q[k]   <= hqnx;
					sq_q[k]   <= sqnx;
					side_q[k] <= sdin;
				end
			end
		end
	endgenerate

	assign in_ready  = rdy[0];
	assign out_valid = valid_q[NSTG-1];
	assign hue_quot  = hq_q[NSTG-1];
	assign sat_quot  = sq_q[NSTG-1];
	assign out_side  = side_q[NSTG-1];

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming RGB to HSV converter. Pixels go in
// on a valid/ready channel; each HSV transfer out is compared field by field
// with the result recorded when the pixel was accepted, under random idling on
// both sides.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FRAC_BITS   = 16;
	localparam longint unsigned FIX_ONE = longint'(1) << FRAC_BITS;
	// Leave a good margin past the pipeline depth for the drain
	localparam int DRAIN_CYCLES = 40;
	// Slowest run: ~1130 pixels, each at worst a sender gap plus a long
	// receiver stall, plus the pipeline depth; take that many times over
	localparam int CYCLE_LIMIT  = 200000;

	// One row of directed stimulus; 'known' rows carry a typed-in result
	typedef struct packed {
		rgbhsv_pkg::pixel_t pix;
		logic               known;
		rgbhsv_pkg::hsv_t   want;
	} stim_row_t;

	localparam int N_DIRECTED = 24;

	// Rows with known = 0 are checked against predict_hsv
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		// black, white, mid grey: no hue, no saturation
		'{ {8'd0,   8'd0,   8'd0  }, 1'b1, {16'd0,     16'd0,     8'd0  } },
		'{ {8'd255, 8'd255, 8'd255}, 1'b1, {16'd0,     16'd0,     8'd255} },
		'{ {8'd128, 8'd128, 8'd128}, 1'b1, {16'd0,     16'd0,     8'd128} },
		// primaries and secondaries: saturation 1.0 clamps to all ones
		'{ {8'd255, 8'd0,   8'd0  }, 1'b1, {16'd0,     16'd65535, 8'd255} },
		'{ {8'd0,   8'd255, 8'd0  }, 1'b1, {16'd21845, 16'd65535, 8'd255} },
		'{ {8'd0,   8'd0,   8'd255}, 1'b1, {16'd43690, 16'd65535, 8'd255} },
		'{ {8'd255, 8'd255, 8'd0  }, 1'b1, {16'd10922, 16'd65535, 8'd255} },
		'{ {8'd0,   8'd255, 8'd255}, 1'b1, {16'd32768, 16'd65535, 8'd255} },
		'{ {8'd255, 8'd0,   8'd255}, 1'b1, {16'd54613, 16'd65535, 8'd255} },
		// smallest non-black pixels
		'{ {8'd1,   8'd0,   8'd0  }, 1'b1, {16'd0,     16'd65535, 8'd1  } },
		'{ {8'd0,   8'd0,   8'd1  }, 1'b1, {16'd43690, 16'd65535, 8'd1  } },
		'{ {8'd0,   8'd1,   8'd0  }, 1'b0, '0 },
		// red sector just short of the wrap, ties on the maximum, near-grey pixels
		'{ {8'd255, 8'd0,   8'd1  }, 1'b0, '0 },
		'{ {8'd255, 8'd255, 8'd1  }, 1'b0, '0 },
		'{ {8'd254, 8'd255, 8'd255}, 1'b0, '0 },
		'{ {8'd255, 8'd254, 8'd254}, 1'b0, '0 },
		'{ {8'd254, 8'd255, 8'd254}, 1'b0, '0 },
		// one step of delta
		'{ {8'd10,  8'd10,  8'd11 }, 1'b0, '0 },
		'{ {8'd11,  8'd10,  8'd10 }, 1'b0, '0 },
		// ordinary colours, each sector at least once
		'{ {8'd200, 8'd100, 8'd50 }, 1'b0, '0 },
		'{ {8'd50,  8'd200, 8'd100}, 1'b0, '0 },
		'{ {8'd100, 8'd50,  8'd200}, 1'b0, '0 },
		'{ {8'd128, 8'd255, 8'd1  }, 1'b0, '0 },
		'{ {8'd170, 8'd85,  8'd170}, 1'b0, '0 }
	};

	logic clk;
	logic arst_n;

	rgbhsv_stream_if #(.T(rgbhsv_pkg::pixel_t)) pix_ch ();
	rgbhsv_stream_if #(.T(rgbhsv_pkg::hsv_t))   hsv_ch ();

	rgb_to_hsv_converter #(
		.FRAC_BITS (FRAC_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix_in  (pix_ch.sink),
		.hsv_out (hsv_ch.source)
	);

	// Results still owed by the converter, oldest first
	rgbhsv_pkg::hsv_t hsv_pending[$];
	int   mismatch_count = 0;
	int   cycle_count    = 0;
	// Idle odds in percent, changed per phase by the stimulus process
	int   tx_idle_pct    = 0;
	int   rx_stall_pct   = 0;

	// Clock: 10 ns period
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact HSV of one pixel: floor of the rational quotients at FRAC_BITS
	function automatic rgbhsv_pkg::hsv_t predict_hsv(input rgbhsv_pkg::pixel_t pix);
		longint unsigned r, g, b, top, bottom, delta, num, q;
		rgbhsv_pkg::sector_t sector;
		rgbhsv_pkg::hsv_t    res;
		r      = pix.red;
		g      = pix.green;
		b      = pix.blue;
		top    = (r >= g) ? r : g;
		if (b > top) top = b;
		bottom = (r <= g) ? r : g;
		if (b < bottom) bottom = b;
		delta  = top - bottom;
		res.value = rgbhsv_pkg::chan_t'(top);

		// Saturation: delta/max, with exact 1.0 clamped to all ones
		if (top == 0) begin
			res.saturation = '0;
		end else begin
			q = (delta << FRAC_BITS) / top;
			if (q >= FIX_ONE) q = FIX_ONE - 1;
			res.saturation = q[rgbhsv_pkg::SAT_W-1:0];
		end

		// Hue: sector picked red first, then green, then blue on ties
		if (delta == 0) begin
			res.hue = '0;
		end else begin
			if (top == r)      sector = rgbhsv_pkg::SECT_RED;
			else if (top == g) sector = rgbhsv_pkg::SECT_GREEN;
			else               sector = rgbhsv_pkg::SECT_BLUE;
			case (sector)
				rgbhsv_pkg::SECT_RED: begin
					num = (g >= b) ? g - b : 6 * delta - (b - g);
				end
				rgbhsv_pkg::SECT_GREEN: begin
					num = 2 * delta + b - r;
				end
				default: begin
					num = 4 * delta + r - g;
				end
			endcase
			q = (num << FRAC_BITS) / (6 * delta);
			if (q >= FIX_ONE) q -= FIX_ONE;
			res.hue = q[rgbhsv_pkg::HUE_W-1:0];
		end
		return res;
	endfunction

	// Random pixel, weighted towards greys, ties on the maximum, a zero
	// minimum and the corners of the range; half are plain uniform
	function automatic rgbhsv_pkg::pixel_t random_pixel();
		rgbhsv_pkg::pixel_t pix;
		rgbhsv_pkg::chan_t  hi, lo;
		int                 slot;
		hi   = rgbhsv_pkg::chan_t'($urandom_range(255));
		lo   = rgbhsv_pkg::chan_t'($urandom_range(hi));
		slot = $urandom_range(2);
		case ($urandom_range(9))
			5: begin
				pix = {hi, hi, hi};
			end
			6: begin
				// two channels share the maximum, the third sits below
				pix = {hi, hi, hi};
				if (slot == 0)      pix.red   = lo;
				else if (slot == 1) pix.green = lo;
				else                pix.blue  = lo;
			end
			7: begin
				pix = {rgbhsv_pkg::chan_t'($urandom_range(255)),
					rgbhsv_pkg::chan_t'($urandom_range(255)),
					rgbhsv_pkg::chan_t'($urandom_range(255))};
				if (slot == 0)      pix.red   = '0;
				else if (slot == 1) pix.green = '0;
				else                pix.blue  = '0;
			end
			8: begin
				pix = {rgbhsv_pkg::chan_t'($urandom_range(3)),
					rgbhsv_pkg::chan_t'($urandom_range(3)),
					rgbhsv_pkg::chan_t'($urandom_range(3))};
			end
			9: begin
				pix = {rgbhsv_pkg::chan_t'($urandom_range(255, 252)),
					rgbhsv_pkg::chan_t'($urandom_range(255, 252)),
					rgbhsv_pkg::chan_t'($urandom_range(255, 252))};
			end
			default: begin
				pix = {rgbhsv_pkg::chan_t'($urandom_range(255)),
					rgbhsv_pkg::chan_t'($urandom_range(255)),
					rgbhsv_pkg::chan_t'($urandom_range(255))};
			end
		endcase
		return pix;
	endfunction

	// Offer one pixel, idling first at the phase's odds, and hold it until
	// the transfer; record what the converter owes for it
	task automatic send_pixel(input rgbhsv_pkg::pixel_t pix, input logic known,
		input rgbhsv_pkg::hsv_t want);
		while ($urandom_range(99) < tx_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.data  <= pix;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		hsv_pending.push_back(known ? want : predict_hsv(pix));
	endtask

	// Drop valid and hold off until every owed result has come out
	task automatic drain_results();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (hsv_pending.size() != 0) @(posedge clk);
	endtask

	// Stimulus: directed table, then three random phases with different
	// idling on each side; the sender drains the pipe between phases
	initial begin
		pix_ch.valid  <= 1'b0;
		pix_ch.data   <= '0;
		arst_n        <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct  = 28;
		rx_stall_pct = 57;
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_pixel(DIRECTED[i].pix, DIRECTED[i].known, DIRECTED[i].want);
		end
		for (int n = 0; n < 370; n++) send_pixel(random_pixel(), 1'b0, '0);
		drain_results();

		tx_idle_pct  = 57;
		rx_stall_pct = 28;
		for (int n = 0; n < 370; n++) send_pixel(random_pixel(), 1'b0, '0);
		drain_results();

		// Back to back in both directions
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		for (int n = 0; n < 360; n++) send_pixel(random_pixel(), 1'b0, '0);
		drain_results();

		// Any stray result in this window is caught by the checker
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Receiver: stall at the phase's odds, redrawn every cycle
	always @(posedge clk) begin
		hsv_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Checker: compare every output transfer with the oldest owed result
	always @(posedge clk) begin
		rgbhsv_pkg::hsv_t want;
		rgbhsv_pkg::hsv_t got;
		if (arst_n && hsv_ch.valid && hsv_ch.ready) begin
			got = hsv_ch.data;
			if (hsv_pending.size() == 0) begin
				$display("%0t: unexpected result, hue %0d saturation %0d value %0d",
					$time, got.hue, got.saturation, got.value);
				mismatch_count++;
			end else begin
				want = hsv_pending.pop_front();
				if (got.hue !== want.hue) begin
					$display("%0t: hue mismatch, expected %0d, actual %0d",
						$time, want.hue, got.hue);
					mismatch_count++;
				end
				if (got.saturation !== want.saturation) begin
					$display("%0t: saturation mismatch, expected %0d, actual %0d",
						$time, want.saturation, got.saturation);
					mismatch_count++;
				end
				if (got.value !== want.value) begin
					$display("%0t: value mismatch, expected %0d, actual %0d",
						$time, want.value, got.value);
					mismatch_count++;
				end
			end
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, hsv_pending.size());
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
